// ===== hw/rtl/i2c_ee_pkg.sv =====
// Shared types and constants for the I2C EEPROM block transfer master.
package i2c_ee_pkg;

  localparam int DATA_BYTES = 4;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_HI  = 5'd1;
  localparam logic [4:0] PH_START_LO  = 5'd2;
  localparam logic [4:0] PH_TX_LOW    = 5'd3;
  localparam logic [4:0] PH_TX_HIGH   = 5'd4;
  localparam logic [4:0] PH_ACK_LOW   = 5'd5;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
  localparam logic [4:0] PH_RX_LOW    = 5'd7;
  localparam logic [4:0] PH_RX_HIGH   = 5'd8;
  localparam logic [4:0] PH_MACK_LOW  = 5'd9;
  localparam logic [4:0] PH_MACK_HIGH = 5'd10;
  localparam logic [4:0] PH_RS_LOW    = 5'd11;
  localparam logic [4:0] PH_STOP_LOW  = 5'd12;
  localparam logic [4:0] PH_STOP_HIGH = 5'd13;

  localparam logic [1:0] SEG_DEVW = 2'd0;
  localparam logic [1:0] SEG_WORD = 2'd1;
  localparam logic [1:0] SEG_DEVR = 2'd2;
  localparam logic [1:0] SEG_DATA = 2'd3;

  localparam logic [3:0] LAST_BYTE = 4'(DATA_BYTES);
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  word_addr;
    logic [31:0] write_data;
    logic        sda_in;
  } ee_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [31:0] read_data;
  } ee_result_t;

endpackage

// ===== hw/rtl/i2c_ee_fsm.sv =====
// Bus sequencer: transfer state registers and the per-tick next-state and line logic.
module i2c_ee_fsm
  import i2c_ee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  ee_item_t   item,
  input  logic [6:0] device_address,
  output ee_result_t result
);

  logic [4:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [31:0] data_buffer, data_buffer_next;
  logic [7:0]  address_latch, address_latch_next;
  logic [1:0]  mode, mode_next;
  logic        failed, failed_next;
  logic [1:0]  segment, segment_next;

  logic [3:0]  bit_inc;
  logic [3:0]  byte_inc;
  logic [7:0]  rx_byte;
  logic        more_bytes;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    byte_count_next    = byte_count;
    shift_byte_next    = shift_byte;
    data_buffer_next   = data_buffer;
    address_latch_next = address_latch;
    mode_next          = mode;
    failed_next        = failed;
    segment_next       = segment;
    bit_inc            = bit_count + 4'd1;
    byte_inc           = {1'b0, byte_count} + 4'd1;
    rx_byte            = {shift_byte[6:0], item.sda_in};

    case (phase)
      PH_IDLE: begin
        if (item.command == CMD_WRITE || item.command == CMD_READ) begin
          mode_next          = item.command;
          address_latch_next = item.word_addr;
          data_buffer_next   = (item.command == CMD_WRITE) ? item.write_data : 32'd0;
          failed_next        = 1'b0;
          byte_count_next    = 3'd0;
          segment_next       = SEG_DEVW;
          shift_byte_next    = {device_address, 1'b0};
          bit_count_next     = 4'd0;
          phase_next         = PH_START_LO;
        end
      end
      PH_START_HI: phase_next = PH_START_LO;
      PH_START_LO: begin
        bit_count_next = 4'd0;
        phase_next     = PH_TX_LOW;
      end
      PH_TX_LOW: phase_next = PH_TX_HIGH;
      PH_TX_HIGH: begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_inc;
        phase_next      = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
      end
      PH_ACK_LOW: phase_next = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (item.sda_in && !(segment == SEG_WORD && mode == CMD_READ)) begin
          failed_next = 1'b1;
          phase_next  = PH_STOP_LOW;
        end else if (segment == SEG_DEVW) begin
          segment_next    = SEG_WORD;
          shift_byte_next = address_latch;
          bit_count_next  = 4'd0;
          phase_next      = PH_TX_LOW;
        end else if (segment == SEG_WORD) begin
          if (mode == CMD_READ) begin
            phase_next = PH_RS_LOW;
          end else begin
            segment_next     = SEG_DATA;
            byte_count_next  = 3'd0;
            shift_byte_next  = data_buffer[31:24];
            data_buffer_next = {data_buffer[23:0], 8'd0};
            bit_count_next   = 4'd0;
            phase_next       = PH_TX_LOW;
          end
        end else if (segment == SEG_DEVR) begin
          segment_next    = SEG_DATA;
          byte_count_next = 3'd0;
          bit_count_next  = 4'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_RX_LOW;
        end else begin
          if (byte_inc >= LAST_BYTE) begin
            phase_next = PH_STOP_LOW;
          end else begin
            byte_count_next  = byte_inc[2:0];
            shift_byte_next  = data_buffer[31:24];
            data_buffer_next = {data_buffer[23:0], 8'd0};
            bit_count_next   = 4'd0;
            phase_next       = PH_TX_LOW;
          end
        end
      end
      PH_RS_LOW: begin
        segment_next    = SEG_DEVR;
        shift_byte_next = {device_address, 1'b1};
        bit_count_next  = 4'd0;
        phase_next      = PH_START_HI;
      end
      PH_RX_LOW: phase_next = PH_RX_HIGH;
      PH_RX_HIGH: begin
        shift_byte_next = rx_byte;
        bit_count_next  = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          data_buffer_next = {data_buffer[23:0], rx_byte};
          phase_next       = PH_MACK_LOW;
        end else begin
          phase_next = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: phase_next = PH_MACK_HIGH;
      PH_MACK_HIGH: begin
        if (byte_inc >= LAST_BYTE) begin
          phase_next = PH_STOP_LOW;
        end else begin
          byte_count_next = byte_inc[2:0];
          bit_count_next  = 4'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_RX_LOW;
        end
      end
      PH_STOP_LOW:  phase_next = PH_STOP_HIGH;
      PH_STOP_HIGH: phase_next = PH_IDLE;
      default:      phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    more_bytes          = ({1'b0, byte_count_next} + 4'd1) < LAST_BYTE;
    result.scl_level    = 1'b1;
    result.sda_pull_low = 1'b0;
    result.busy_res     = (phase_next != PH_IDLE);
    result.done_res     = (phase == PH_STOP_HIGH);
    result.success      = (phase == PH_STOP_HIGH) && !failed;
    result.read_data    = (mode_next == CMD_READ) ? data_buffer_next : 32'd0;
    case (phase_next)
      PH_START_LO: result.sda_pull_low = 1'b1;
      PH_TX_LOW: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = !shift_byte_next[7];
      end
      PH_TX_HIGH: result.sda_pull_low = !shift_byte_next[7];
      PH_ACK_LOW, PH_RX_LOW, PH_RS_LOW: result.scl_level = 1'b0;
      PH_MACK_LOW: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = more_bytes;
      end
      PH_MACK_HIGH: result.sda_pull_low = more_bytes;
      PH_STOP_LOW: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = 1'b1;
      end
      PH_STOP_HIGH: result.sda_pull_low = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 4'd0;
      byte_count    <= 3'd0;
      shift_byte    <= 8'd0;
      data_buffer   <= 32'd0;
      address_latch <= 8'd0;
      mode          <= 2'd0;
      failed        <= 1'b0;
      segment       <= SEG_DEVW;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      byte_count    <= byte_count_next;
      shift_byte    <= shift_byte_next;
      data_buffer   <= data_buffer_next;
      address_latch <= address_latch_next;
      mode          <= mode_next;
      failed        <= failed_next;
      segment       <= segment_next;
    end
  end

endmodule

// ===== hw/rtl/i2c_ee_out.sv =====
// Result register that holds one transaction on the master side until it is taken.
module i2c_ee_out
  import i2c_ee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  ee_result_t result,
  input  logic       m_tready,
  output logic       m_tvalid,
  output ee_result_t held,
  output logic       room
);

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== hw/rtl/i2c_eeprom_block_transfer_top.sv =====
// Top level of the I2C EEPROM block transfer master with stream ports.
// Each accepted transaction yields its result in the next cycle; the sequencer step is
// a single registered pass. One transaction per cycle unless m_tready stalls the output.
// Reset: synchronous, clears the sequencer to idle and the result register to empty.
// Reset also sets device_address to 80.
module i2c_eeprom_block_transfer_top
  import i2c_ee_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // word_addr[7:0], write_data[39:8], sda_in[40]
  input  logic [1:0]             s_tuser,  // command[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3], success[4], read_data[36:5]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [6:0]             cfg_data
);

  logic [6:0] dev_addr;
  logic       accept;
  logic       room;
  ee_item_t   item;
  ee_result_t result;
  ee_result_t held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr <= cfg_data;
    end
  end

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  assign item.command    = s_tuser;
  assign item.word_addr  = s_tdata[7:0];
  assign item.write_data = s_tdata[39:8];
  assign item.sda_in     = s_tdata[40];

  i2c_ee_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .item           (item),
    .device_address (dev_addr),
    .result         (result)
  );

  i2c_ee_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .held     (held),
    .room     (room)
  );

  assign m_tdata = {3'd0, held.read_data, held.success, held.done_res,
                    held.busy_res, held.sda_pull_low, held.scl_level};

endmodule

// ===== hw/rtl/i2c_ee_checker.sv =====
// Port-level checker for the I2C EEPROM block transfer master, with its bind.
module i2c_ee_assertions
  import i2c_ee_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [1:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [6:0]             cfg_data
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
    else $error("transfer finished while still busy");

  a_success_done : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> m_tdata[3])
    else $error("success reported outside a finished transfer");

  a_ready_follows : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while a stalled result has no room");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind i2c_eeprom_block_transfer_top i2c_ee_assertions u_i2c_ee_assertions (.*);
